FILE: rtl/ctrr_pkg.sv
package ctrr_pkg;

	localparam int FRAME_W     = 64;
	localparam int CHUNK_W     = 56;
	localparam int LEN_W       = 12;
	localparam int CNT_W       = 8;
	localparam int FRAMES_W    = 10;
	localparam int NBYTES_W    = 3;
	localparam int STATUS_W    = 2;
	localparam int M_TDATA_W   = 88;

	localparam logic [CNT_W-1:0] PENDING_LIMIT_RST = 8'd200;

	localparam logic [7:0] PCI_SF_NEG    = 8'h03;
	localparam logic [7:0] SID_NEG       = 8'h7F;
	localparam logic [7:0] NRC_PENDING   = 8'h78;
	localparam logic [7:0] PCI_FF_MASK   = 8'h10;
	localparam logic [3:0] PCI_LEN_MASK  = 4'hF;
	localparam logic [LEN_W-1:0] FF_DATA_BYTES = 12'd6;
	localparam logic [NBYTES_W-1:0] CF_DATA_BYTES = 3'd7;
	localparam logic [NBYTES_W-1:0] NEG_BYTES = 3'd3;

	// len / 7 == (len * 4682) >> 15 for every 12-bit len
	localparam int DIV7_SHIFT = 15;
	localparam logic [12:0] DIV7_MUL = 13'd4682;
	localparam int DIV7_PROD_W = LEN_W + 13;

	typedef enum logic [2:0] {
		PH_FIRST   = 3'b001,
		PH_PENDING = 3'b010,
		PH_CONSEC  = 3'b100
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_BUSY    = 2'd0,
		ST_OK      = 2'd1,
		ST_NEG     = 2'd2,
		ST_TIMEOUT = 2'd3
	} status_t;

	typedef enum logic {
		ACT_FRAME   = 1'b0,
		ACT_TIMEOUT = 1'b1
	} action_t;

	typedef struct packed {
		phase_t                phase;
		logic [CNT_W-1:0]      pending_count;
		logic [LEN_W-1:0]      total_length;
		logic [LEN_W-1:0]      next_offset;
		logic [FRAMES_W-1:0]   frames_left;
	} rx_state_t;

	typedef struct packed {
		status_t               status;
		logic [CHUNK_W-1:0]    chunk_data;
		logic [NBYTES_W-1:0]   chunk_bytes;
		logic [LEN_W-1:0]      chunk_offset;
		logic [LEN_W-1:0]      message_length;
		logic                  last;
	} result_t;

	// keep the top n bytes of d
	function automatic logic [CHUNK_W-1:0] take_bytes(logic [CHUNK_W-1:0] d,
			logic [NBYTES_W-1:0] n);
		logic [CHUNK_W-1:0] mask;
		mask = ~({CHUNK_W{1'b1}} >> {n, 3'b000});
		return d & mask;
	endfunction

endpackage

FILE: rtl/ctrr_step.sv
module ctrr_step (
	input  ctrr_pkg::rx_state_t                 cur,
	input  logic                                action,
	input  logic [ctrr_pkg::FRAME_W-1:0]        frame_bytes,
	input  logic [ctrr_pkg::CNT_W-1:0]          pending_limit,
	output ctrr_pkg::rx_state_t                 nxt,
	output logic                                res_valid,
	output ctrr_pkg::result_t                   res
);
	import ctrr_pkg::*;

	logic [7:0]              b0, b1, b3;
	logic [CHUNK_W-1:0]      from1, from2;
	logic [LEN_W-1:0]        ff_len;
	logic [LEN_W-1:0]        rem;
	logic [NBYTES_W-1:0]     cf_n;
	logic [NBYTES_W-1:0]     sf_n;
	logic                    cf_fin;
	logic [DIV7_PROD_W-1:0]  div_prod;
	logic [FRAMES_W-1:0]     ff_frames;
	logic                    is_neg;
	logic [CNT_W-1:0]        cnt_inc;

	assign b0 = frame_bytes[63:56];
	assign b1 = frame_bytes[55:48];
	assign b3 = frame_bytes[39:32];
	assign from1 = frame_bytes[55:0];
	assign from2 = {frame_bytes[47:0], 8'h00};
	assign ff_len = {b0[3:0] & PCI_LEN_MASK, b1};
	assign rem = (cur.total_length > cur.next_offset) ?
		(cur.total_length - cur.next_offset) : '0;
	assign cf_n = (rem > LEN_W'(CF_DATA_BYTES)) ? CF_DATA_BYTES : rem[NBYTES_W-1:0];
	assign cf_fin = cur.frames_left <= FRAMES_W'(1);
	assign sf_n = (b0 > 8'(CF_DATA_BYTES)) ? CF_DATA_BYTES : b0[NBYTES_W-1:0];
	assign div_prod = DIV7_PROD_W'(ff_len) * DIV7_PROD_W'(DIV7_MUL);
	assign ff_frames = div_prod[DIV7_SHIFT +: FRAMES_W];
	assign is_neg = (b0 == PCI_SF_NEG) && (b1 == SID_NEG);
	assign cnt_inc = cur.pending_count + CNT_W'(1);

	always_comb begin
		nxt = cur;
		res_valid = 1'b0;
		res = '0;
		res.status = ST_BUSY;
		if (action == ACT_TIMEOUT) begin
			nxt.phase = PH_FIRST;
			res_valid = 1'b1;
			res.status = ST_TIMEOUT;
			res.last = 1'b1;
		end else if (cur.phase == PH_CONSEC) begin
			nxt.next_offset = cur.next_offset + LEN_W'(cf_n);
			nxt.frames_left = cf_fin ? '0 : cur.frames_left - FRAMES_W'(1);
			if (cf_fin) begin
				nxt.phase = PH_FIRST;
			end
			res_valid = 1'b1;
			res.status = cf_fin ? ST_OK : ST_BUSY;
			res.chunk_data = take_bytes(from1, cf_n);
			res.chunk_bytes = cf_n;
			res.chunk_offset = cur.next_offset;
			res.message_length = cur.total_length;
			res.last = cf_fin;
		end else if (is_neg) begin
			if (b3 == NRC_PENDING) begin
				if (cur.phase == PH_PENDING) begin
					nxt.pending_count = cnt_inc;
					if (cnt_inc == pending_limit) begin
						nxt.phase = PH_FIRST;
						res_valid = 1'b1;
						res.status = ST_TIMEOUT;
						res.last = 1'b1;
					end
				end else begin
					nxt.phase = PH_PENDING;
					nxt.pending_count = '0;
				end
			end else begin
				nxt.phase = PH_FIRST;
				res_valid = 1'b1;
				res.status = ST_NEG;
				res.chunk_data = take_bytes(from1, NEG_BYTES);
				res.chunk_bytes = NEG_BYTES;
				res.message_length = LEN_W'(NEG_BYTES);
				res.last = 1'b1;
			end
		end else if ((b0 & PCI_FF_MASK) == 8'h00) begin
			// single frame
			nxt.phase = PH_FIRST;
			res_valid = 1'b1;
			res.status = ST_OK;
			res.chunk_data = take_bytes(from1, sf_n);
			res.chunk_bytes = sf_n;
			res.message_length = LEN_W'(sf_n);
			res.last = 1'b1;
		end else if (ff_len <= FF_DATA_BYTES) begin
			nxt.phase = PH_FIRST;
			res_valid = 1'b1;
			res.status = ST_OK;
			res.chunk_data = take_bytes(from2, ff_len[NBYTES_W-1:0]);
			res.chunk_bytes = ff_len[NBYTES_W-1:0];
			res.message_length = ff_len;
			res.last = 1'b1;
		end else begin
			nxt.phase = PH_CONSEC;
			nxt.total_length = ff_len;
			nxt.next_offset = FF_DATA_BYTES;
			nxt.frames_left = ff_frames;
			res_valid = 1'b1;
			res.status = ST_BUSY;
			res.chunk_data = take_bytes(from2, FF_DATA_BYTES[NBYTES_W-1:0]);
			res.chunk_bytes = FF_DATA_BYTES[NBYTES_W-1:0];
			res.message_length = ff_len;
			res.last = 1'b0;
		end
	end

endmodule

FILE: rtl/can_transport_receive_reassembly.sv
// Reassembles one diagnostic response from received CAN frames (ID removed) and
// receive-timeout events. Each input beat is registered, decoded against the
// reassembly state combinationally and lands in an output register, so a new
// beat is accepted every cycle while the output is free or being taken; a result
// passes the input register, then the output register. Response-pending frames
// produce no result until the repeat count reaches pending_limit. Consecutive
// frames are not sequence checked and no flow control is generated.
module can_transport_receive_reassembly (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [ctrr_pkg::CNT_W-1:0]          cfg_wdata,   // pending_limit
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ctrr_pkg::FRAME_W-1:0]        s_tdata,     // frame_bytes
	input  logic [0:0]                          s_tuser,     // action
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// chunk_data[55:0], chunk_bytes[58:56], chunk_offset[70:59],
	// message_length[82:71], zero pad
	output logic [ctrr_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic [ctrr_pkg::STATUS_W-1:0]       m_tuser,     // status
	output logic                                m_tlast      // last
);
	import ctrr_pkg::*;

	logic [CNT_W-1:0]    pending_limit_q;
	rx_state_t           state_q;
	rx_state_t           state_nxt;
	logic                valid_s1;
	logic                action_s1;
	logic [FRAME_W-1:0]  frame_s1;
	logic                res_valid;
	result_t             res;
	logic                out_valid_q;
	result_t             out_q;
	logic                out_free;
	logic                advance;

	assign out_free = !out_valid_q || m_tready;
	assign advance = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_limit_q <= PENDING_LIMIT_RST;
		end else if (cfg_wen) begin
			pending_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser[0];
			frame_s1 <= s_tdata;
		end
	end

	ctrr_step u_step (
		.cur           (state_q),
		.action        (action_s1),
		.frame_bytes   (frame_s1),
		.pending_limit (pending_limit_q),
		.nxt           (state_nxt),
		.res_valid     (res_valid),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_FIRST;
			state_q.pending_count <= '0;
			state_q.total_length <= '0;
			state_q.next_offset <= '0;
			state_q.frames_left <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid && out_free) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_q.status;
	assign m_tlast = out_q.last;
	assign m_tdata = {5'b0, out_q.message_length, out_q.chunk_offset,
		out_q.chunk_bytes, out_q.chunk_data};

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	a_last_returns_first: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && res.last) |=> (state_q.phase == PH_FIRST))
		else $error("phase not back to first frame after last beat");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_TIMEOUT) |-> (m_tdata == '0 && m_tlast))
		else $error("timeout beat carries payload");

	a_busy_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == ST_BUSY))
		else $error("non-final beat with final status");

	a_no_result_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> valid_s1)
		else $error("input beat dropped while output stalled");

endmodule
